FILE: rtl/mlcp_pkg.sv
// ----------------------------------------------------------------------------
// mlcp_pkg
// Shared types and constants for the framed byte stream parser.
// ----------------------------------------------------------------------------
package mlcp_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_MAGIC    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LEN  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_REG_CODE = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_XFER_CODE = 2'd3;

  localparam logic [15:0] MagicReset   = 16'd0;
  localparam logic [15:0] MaxLenReset  = 16'd1024;
  localparam logic [15:0] RegCodeReset = 16'd1;
  localparam logic [15:0] XferCodeReset = 16'd2;

  typedef enum logic [1:0] {
    PH_MAGIC = 2'd0,
    PH_LEN   = 2'd1,
    PH_DATA  = 2'd2,
    PH_SUM   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    END_MAGIC_ERR = 2'd0,
    END_LEN_ERR   = 2'd1,
    END_SUM_ERR   = 2'd2,
    END_SUM_OK    = 2'd3
  } end_kind_e;

  typedef enum logic [2:0] {
    ST_REG_OK      = 3'd0,
    ST_XFER_OK     = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_LEN     = 3'd3,
    ST_BAD_SUM     = 3'd4,
    ST_SHORT       = 3'd5,
    ST_REG_SHORT   = 3'd6,
    ST_UNKNOWN_CMD = 3'd7
  } status_e;

  typedef struct packed {
    end_kind_e   kind;
    logic [15:0] len;
    logic [15:0] cmd;
    logic [15:0] grp;
  } frame_end_t;

endpackage

FILE: rtl/mlcp_front.sv
// ----------------------------------------------------------------------------
// mlcp_front
// Byte parser: tracks the frame phase, sums the payload and reports frame ends.
// ----------------------------------------------------------------------------
module mlcp_front
  import mlcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_vld_i,
  input  logic [7:0]  byte_i,
  input  logic [15:0] magic_i,
  input  logic [15:0] max_len_i,
  output logic        end_vld_o,
  output frame_end_t  end_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  hold_q, hold_d;
  logic [15:0] len_q, len_d;
  logic [15:0] sum_q, sum_d;
  logic [15:0] cmd_q, cmd_d;
  logic [15:0] grp_q, grp_d;
  logic [15:0] word;
  logic [16:0] idx_nxt;

  assign word    = {hold_q, byte_i};
  assign idx_nxt = {1'b0, cnt_q} + 17'd1;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    hold_d    = hold_q;
    len_d     = len_q;
    sum_d     = sum_q;
    cmd_d     = cmd_q;
    grp_d     = grp_q;
    end_vld_o = 1'b0;
    end_o     = '{kind: END_MAGIC_ERR, len: 16'd0, cmd: cmd_q, grp: grp_q};
    if (byte_vld_i) begin
      unique case (phase_q)
        PH_MAGIC: begin
          if (cnt_q == 16'd0) begin
            hold_d = byte_i;
            cnt_d  = 16'd1;
          end else begin
            cnt_d = 16'd0;
            if (word != magic_i) begin
              end_vld_o = 1'b1;
            end else begin
              phase_d = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          if (cnt_q == 16'd0) begin
            hold_d = byte_i;
            cnt_d  = 16'd1;
          end else begin
            cnt_d = 16'd0;
            if (word == 16'd0 || word > max_len_i) begin
              end_vld_o = 1'b1;
              end_o.kind = END_LEN_ERR;
              end_o.len  = word;
              phase_d    = PH_MAGIC;
            end else begin
              len_d   = word;
              sum_d   = 16'd0;
              cmd_d   = 16'd0;
              grp_d   = 16'd0;
              phase_d = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          sum_d = sum_q + {8'd0, byte_i};
          case (cnt_q)
            16'd0:   cmd_d[15:8] = byte_i;
            16'd1:   cmd_d[7:0]  = byte_i;
            16'd2:   grp_d[15:8] = byte_i;
            16'd3:   grp_d[7:0]  = byte_i;
            default: ;
          endcase
          if (idx_nxt >= {1'b0, len_q}) begin
            phase_d = PH_SUM;
            cnt_d   = 16'd0;
          end else begin
            cnt_d = idx_nxt[15:0];
          end
        end
        PH_SUM: begin
          if (cnt_q == 16'd0) begin
            hold_d = byte_i;
            cnt_d  = 16'd1;
          end else begin
            cnt_d      = 16'd0;
            phase_d    = PH_MAGIC;
            end_vld_o  = 1'b1;
            end_o.len  = len_q;
            end_o.kind = (word == sum_q) ? END_SUM_OK : END_SUM_ERR;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC;
      cnt_q   <= 16'd0;
      hold_q  <= 8'd0;
      len_q   <= 16'd0;
      sum_q   <= 16'd0;
      cmd_q   <= 16'd0;
      grp_q   <= 16'd0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      hold_q  <= hold_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      cmd_q   <= cmd_d;
      grp_q   <= grp_d;
    end
  end

endmodule

FILE: rtl/mlcp_fifo.sv
// ----------------------------------------------------------------------------
// mlcp_fifo
// Two-entry queue of frame-end requests between the parser and the classifier.
// ----------------------------------------------------------------------------
module mlcp_fifo
  import mlcp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_i,
  input  frame_end_t wr_data_i,
  output logic       full_o,
  input  logic       rd_i,
  output logic       vld_o,
  output frame_end_t rd_data_o
);

  frame_end_t  mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        do_wr, do_rd;

  assign full_o    = (cnt_q == 2'd2);
  assign vld_o     = (cnt_q != 2'd0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && vld_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_rd) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/mlcp_back.sv
// ----------------------------------------------------------------------------
// mlcp_back
// Classifier: turns a frame-end request into a status result and holds it.
// ----------------------------------------------------------------------------
module mlcp_back
  import mlcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_vld_i,
  input  frame_end_t  req_i,
  output logic        req_rd_o,
  input  logic [15:0] reg_code_i,
  input  logic [15:0] xfer_code_i,
  output logic        res_vld_o,
  input  logic        res_pop_i,
  output status_e     status_o,
  output logic [15:0] command_o,
  output logic [15:0] group_word_o,
  output logic [15:0] payload_len_o
);

  logic        vld_q;
  status_e     status_q, status_d;
  logic [15:0] cmd_q, cmd_d;
  logic [15:0] grp_q, grp_d;
  logic [15:0] len_q, len_d;
  logic        take;

  assign take      = req_vld_i && (!vld_q || res_pop_i);
  assign req_rd_o  = take;
  assign res_vld_o = vld_q;
  assign status_o  = status_q;
  assign command_o = cmd_q;
  assign group_word_o = grp_q;
  assign payload_len_o = len_q;

  always_comb begin
    status_d = ST_BAD_MAGIC;
    cmd_d    = 16'd0;
    grp_d    = 16'd0;
    len_d    = req_i.len;
    unique case (req_i.kind)
      END_MAGIC_ERR: len_d = 16'd0;
      END_LEN_ERR:   status_d = ST_BAD_LEN;
      END_SUM_ERR:   status_d = ST_BAD_SUM;
      END_SUM_OK: begin
        if (req_i.len <= 16'd2) begin
          status_d = ST_SHORT;
        end else if (req_i.cmd == reg_code_i) begin
          cmd_d = req_i.cmd;
          if (req_i.len >= 16'd4) begin
            status_d = ST_REG_OK;
            grp_d    = req_i.grp;
          end else begin
            status_d = ST_REG_SHORT;
          end
        end else if (req_i.cmd == xfer_code_i) begin
          status_d = ST_XFER_OK;
          cmd_d    = req_i.cmd;
        end else begin
          status_d = ST_UNKNOWN_CMD;
          cmd_d    = req_i.cmd;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q <= status_d;
      cmd_q    <= cmd_d;
      grp_q    <= grp_d;
      len_q    <= len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (res_pop_i) begin
      vld_q <= 1'b0;
    end
  end

endmodule

FILE: rtl/magic_length_checksum_frame_parser.sv
// Path: a frame end is queued, then classified into the registered result.
// Throughput: one byte per cycle unless the two-entry request queue is full; the
// queue drains one per cycle while results are popped, and stalls when one is held.
// Reset: asynchronous, active low; configuration returns to its defaults and
// the parser returns to hunting for the magic with no results pending.
// ----------------------------------------------------------------------------
// magic_length_checksum_frame_parser
// Deframes magic / length / payload / checksum packets from a byte stream.
// ----------------------------------------------------------------------------
module magic_length_checksum_frame_parser
  import mlcp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         status_o,
  output logic [15:0]        command_o,
  output logic [15:0]        group_word_o,
  output logic [15:0]        payload_len_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);

  logic [15:0] magic_q, max_len_q, reg_code_q, xfer_code_q;
  logic        q_full, q_vld, q_rd, end_vld, res_vld;
  frame_end_t  end_req, q_req;
  status_e     status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q     <= MagicReset;
      max_len_q   <= MaxLenReset;
      reg_code_q  <= RegCodeReset;
      xfer_code_q <= XferCodeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAGIC:     magic_q     <= cfg_data_i;
        CFG_MAX_LEN:   max_len_q   <= cfg_data_i;
        CFG_REG_CODE:  reg_code_q  <= cfg_data_i;
        CFG_XFER_CODE: xfer_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign full = q_full;

  mlcp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_vld_i (push && !q_full),
    .byte_i     (data_byte_i),
    .magic_i    (magic_q),
    .max_len_i  (max_len_q),
    .end_vld_o  (end_vld),
    .end_o      (end_req)
  );

  mlcp_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (end_vld),
    .wr_data_i (end_req),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .vld_o     (q_vld),
    .rd_data_o (q_req)
  );

  mlcp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_vld_i     (q_vld),
    .req_i         (q_req),
    .req_rd_o      (q_rd),
    .reg_code_i    (reg_code_q),
    .xfer_code_i   (xfer_code_q),
    .res_vld_o     (res_vld),
    .res_pop_i     (pop),
    .status_o      (status),
    .command_o     (command_o),
    .group_word_o  (group_word_o),
    .payload_len_o (payload_len_o)
  );

  assign empty    = !res_vld;
  assign status_o = status;

endmodule
